### src/pps_pkg.sv
// Shared types, codes and constants for the pick-and-place sequencer.
// No dependencies; pps_cfg_regs, pps_seq and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAW_TIME  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SORT_COL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRED_ROT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRED_DIST  = 3'd4;
    localparam int CFG_DATA_W = 16;

    // Build-time defaults
    localparam int GRID_CELLS     = 9;
    localparam int TIME_BITS_DEF  = 32;

    // Task machine codes
    localparam logic [1:0] T_WAIT = 2'd0;
    localparam logic [1:0] T_PICK = 2'd1;
    localparam logic [1:0] T_READ = 2'd2;
    localparam logic [1:0] T_SORT = 2'd3;

    // Move machine codes
    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_ROT  = 3'd1;
    localparam logic [2:0] M_ADV  = 3'd2;
    localparam logic [2:0] M_CLAW = 3'd3;
    localparam logic [2:0] M_RETR = 3'd4;
    localparam logic [2:0] M_FIN  = 3'd5;

    // Command bytes
    localparam logic [7:0] KEY_START = 8'h7A;  // 'z'
    localparam logic [7:0] KEY_PRED  = 8'h70;  // 'p'
    localparam logic [7:0] KEY_ONE   = 8'h31;  // '1'
    localparam logic [7:0] KEY_NINE  = 8'h39;  // '9'

    // Sort bins
    localparam logic [1:0] COL_YELLOW = 2'd1;
    localparam logic [1:0] COL_GREEN  = 2'd2;
    localparam logic [6:0] BIN_YELLOW_ROT = 7'd11;
    localparam logic [6:0] BIN_GREEN_ROT  = 7'd5;
    localparam logic [6:0] READ_POS       = 7'd100;

    // Duty scaling, thousandths of a percent
    localparam logic [13:0] ROT_GAIN    = 14'd92;
    localparam logic [13:0] ROT_OFFS    = 14'd4000;
    localparam logic [12:0] LIFT_GAIN   = 13'd12;
    localparam logic [12:0] LIFT_OFFS   = 13'd1900;
    localparam logic [12:0] LIFT_RAISED = 13'd4900;
    localparam logic [12:0] REACH_GAIN  = 13'd28;
    localparam logic [12:0] REACH_OFFS  = 13'd3700;
    localparam logic [12:0] REACH_RAISED = 13'd6500;
    localparam logic [13:0] CLAW_OPEN   = 14'd11500;
    localparam logic [13:0] CLAW_CLOSED = 14'd2000;
    localparam logic [13:0] HOME_ROT    = 14'd9612;   // rotation 61

    typedef struct packed {
        logic [31:0] now_ms;
        logic        key_valid;
        logic [7:0]  key_byte;
    } item_t;

    typedef struct packed {
        logic        arm_update;
        logic [13:0] rot_duty;
        logic [12:0] lift_duty;
        logic [12:0] reach_duty;
        logic        claw_update;
        logic [13:0] claw_duty;
        logic [1:0]  task_phase;
        logic [2:0]  move_phase;
    } result_t;

    typedef struct packed {
        logic [15:0] phase_time_ms;
        logic [15:0] claw_time_ms;
        logic [1:0]  sort_colour;
        logic [6:0]  pred_rot;
        logic [6:0]  pred_dist;
    } cfg_t;

    typedef struct packed {
        logic [6:0] rot;
        logic [6:0] reach;
    } pos_t;

    // Grid pick-up points, cells 1..9; anything else maps to cell 1
    function automatic pos_t grid_pos(input logic [3:0] cell_no);
        pos_t p;
        unique case (cell_no)
            4'd2:    p = '{rot: 7'd38, reach: 7'd50};
            4'd3:    p = '{rot: 7'd38, reach: 7'd0};
            4'd4:    p = '{rot: 7'd61, reach: 7'd100};
            4'd5:    p = '{rot: 7'd61, reach: 7'd50};
            4'd6:    p = '{rot: 7'd61, reach: 7'd0};
            4'd7:    p = '{rot: 7'd80, reach: 7'd100};
            4'd8:    p = '{rot: 7'd80, reach: 7'd50};
            4'd9:    p = '{rot: 7'd80, reach: 7'd0};
            default: p = '{rot: 7'd38, reach: 7'd100};
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

### src/pps_if.sv
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on nothing; payload widths follow the field definitions.
`timescale 1ns / 1ps
`default_nettype none

interface pps_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        key_valid;
    logic [7:0]  key_byte;
    modport source (output valid, now_ms, key_valid, key_byte, input ready);
    modport sink   (input valid, now_ms, key_valid, key_byte, output ready);
endinterface

interface pps_out_if;
    logic        valid;
    logic        ready;
    logic        arm_update;
    logic [13:0] rot_duty;
    logic [12:0] lift_duty;
    logic [12:0] reach_duty;
    logic        claw_update;
    logic [13:0] claw_duty;
    logic [1:0]  task_phase;
    logic [2:0]  move_phase;
    modport source (output valid, arm_update, rot_duty, lift_duty, reach_duty,
                    claw_update, claw_duty, task_phase, move_phase, input ready);
    modport sink   (input valid, arm_update, rot_duty, lift_duty, reach_duty,
                    claw_update, claw_duty, task_phase, move_phase, output ready);
endinterface

interface pps_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/pps_cfg_regs.sv
// Configuration register file; always ready, writes land on a transfer.
// Depends on pps_pkg and pps_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module pps_cfg_regs (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pps_cfg_if.sink     cfg,
    output pps_pkg::cfg_t regs
);
    import pps_pkg::*;

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.phase_time_ms <= 16'd1000;
            regs_reg.claw_time_ms  <= 16'd500;
            regs_reg.sort_colour   <= COL_GREEN;
            regs_reg.pred_rot      <= 7'd61;
            regs_reg.pred_dist     <= 7'd50;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_PHASE_TIME: regs_reg.phase_time_ms <= cfg.data;
                CFG_CLAW_TIME:  regs_reg.claw_time_ms  <= cfg.data;
                CFG_SORT_COL:   regs_reg.sort_colour   <= cfg.data[1:0];
                CFG_PRED_ROT:   regs_reg.pred_rot      <= cfg.data[6:0];
                CFG_PRED_DIST:  regs_reg.pred_dist     <= cfg.data[6:0];
                default:        ;
            endcase
        end
    end

endmodule

`default_nettype wire

### src/pps_seq.sv
// Task and move state machines with servo duty scaling for one period.
// Depends on pps_pkg. State advances when step is high; result is combinational.
`timescale 1ns / 1ps
`default_nettype none

module pps_seq #(
    parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  pps_pkg::item_t item,
    input  pps_pkg::cfg_t  cfg,
    output pps_pkg::result_t res
);
    import pps_pkg::*;

    // State registers
    logic [1:0]           task_reg, task_next;
    logic [1:0]           prev_task_reg, prev_task_next;
    logic [2:0]           move_reg, move_next;
    logic [TIME_BITS-1:0] pstart_reg, pstart_next;
    logic                 start_pend_reg, start_pend_next;
    logic                 move_req_reg, move_req_next;
    logic                 move_done_reg, move_done_next;
    logic                 claw_due_reg, claw_due_next;
    logic                 claw_open_reg, claw_open_next;
    logic                 sel_mode_reg, sel_mode_next;
    logic [3:0]           sel_cell_reg, sel_cell_next;
    logic                 act_mode_reg, act_mode_next;
    logic [3:0]           act_cell_reg, act_cell_next;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic                 phase_up;
    logic                 claw_up;
    logic [3:0]           digit;
    pos_t                 tgt;
    logic                 has_tgt;

    assign now_t    = TIME_BITS'(item.now_ms);
    assign elapsed  = now_t - pstart_reg;
    assign phase_up = elapsed >= TIME_BITS'(cfg.phase_time_ms);
    assign claw_up  = elapsed >= TIME_BITS'(cfg.claw_time_ms);
    assign digit    = item.key_byte[3:0];

    // Command byte, task step, then move step
    always_comb
    begin
        task_next       = task_reg;
        prev_task_next  = prev_task_reg;
        move_next       = move_reg;
        pstart_next     = pstart_reg;
        start_pend_next = start_pend_reg;
        move_req_next   = move_req_reg;
        move_done_next  = move_done_reg;
        claw_due_next   = claw_due_reg;
        claw_open_next  = claw_open_reg;
        sel_mode_next   = sel_mode_reg;
        sel_cell_next   = sel_cell_reg;
        act_mode_next   = act_mode_reg;
        act_cell_next   = act_cell_reg;

        // command byte
        if (item.key_valid)
        begin
            priority if (item.key_byte == KEY_START)
            begin
                start_pend_next = 1'b1;
            end
            else if (item.key_byte >= KEY_ONE && item.key_byte <= KEY_NINE &&
                     32'(digit) <= 32'(GRID_CELLS))
            begin
                sel_cell_next = digit;
                sel_mode_next = 1'b1;
            end
            else if (item.key_byte == KEY_PRED)
            begin
                sel_mode_next = 1'b0;
            end
        end

        // task machine
        unique case (task_reg)
            T_WAIT:
            begin
                if (start_pend_next)
                begin
                    start_pend_next = 1'b0;
                    move_req_next   = 1'b1;
                    prev_task_next  = T_SORT;
                    task_next       = T_PICK;
                    move_done_next  = 1'b0;
                    claw_due_next   = 1'b1;
                    act_mode_next   = sel_mode_next;
                    if (sel_mode_next)
                        act_cell_next = sel_cell_next;
                end
            end
            T_PICK, T_READ:
            begin
                if (move_done_reg)
                begin
                    move_done_next = 1'b0;
                    move_req_next  = 1'b1;
                    prev_task_next = task_reg;
                    if (task_reg == T_READ)
                        claw_due_next = 1'b1;
                    task_next = task_reg + 2'd1;
                end
            end
            default:
            begin
                if (move_done_reg)
                begin
                    move_done_next = 1'b0;
                    prev_task_next = task_reg;
                    task_next      = T_WAIT;
                end
            end
        endcase

        // move machine
        unique case (move_reg)
            M_IDLE:
            begin
                if (move_req_next)
                begin
                    prev_task_next = task_next;
                    move_req_next  = 1'b0;
                    move_next      = M_ROT;
                    pstart_next    = now_t;
                end
            end
            M_ROT:
            begin
                if (phase_up)
                begin
                    move_next   = M_ADV;
                    pstart_next = now_t;
                end
            end
            M_ADV:
            begin
                if (phase_up)
                begin
                    pstart_next = now_t;
                    if (claw_due_next)
                    begin
                        move_next      = M_CLAW;
                        claw_open_next = !claw_open_reg;
                        claw_due_next  = 1'b0;
                    end
                    else
                    begin
                        move_next = M_RETR;
                    end
                end
            end
            M_CLAW:
            begin
                if (claw_up)
                begin
                    pstart_next = now_t;
                    move_next   = M_RETR;
                end
            end
            M_RETR:
            begin
                if (phase_up)
                begin
                    move_done_next = 1'b1;
                    move_next      = M_FIN;
                end
            end
            default:
            begin
                if (prev_task_next != task_next)
                    move_next = M_IDLE;
            end
        endcase
    end

    // Target position of the new task
    always_comb
    begin
        tgt     = '{rot: 7'd0, reach: 7'd0};
        has_tgt = 1'b0;
        unique case (task_next)
            T_PICK:
            begin
                has_tgt = 1'b1;
                if (act_mode_next)
                    tgt = grid_pos(act_cell_next);
                else
                    tgt = '{rot: cfg.pred_rot, reach: cfg.pred_dist};
            end
            T_READ:
            begin
                has_tgt = 1'b1;
                tgt     = '{rot: READ_POS, reach: READ_POS};
            end
            T_SORT:
            begin
                if (cfg.sort_colour == COL_YELLOW)
                begin
                    has_tgt = 1'b1;
                    tgt     = '{rot: BIN_YELLOW_ROT, reach: 7'd0};
                end
                else if (cfg.sort_colour == COL_GREEN)
                begin
                    has_tgt = 1'b1;
                    tgt     = '{rot: BIN_GREEN_ROT, reach: 7'd0};
                end
            end
            default: ;
        endcase
    end

    // Servo duties from the new state
    always_comb
    begin
        res = '0;
        res.task_phase = task_next;
        res.move_phase = move_next;
        if (move_next == M_ROT || move_next == M_ADV ||
            (move_next == M_RETR && task_next != T_READ))
        begin
            if (has_tgt)
            begin
                res.arm_update = 1'b1;
                res.rot_duty   = 14'(tgt.rot) * ROT_GAIN + ROT_OFFS;
                if (move_next == M_ADV)
                begin
                    res.lift_duty  = 13'(tgt.reach) * LIFT_GAIN + LIFT_OFFS;
                    res.reach_duty = 13'(tgt.reach) * REACH_GAIN + REACH_OFFS;
                end
                else
                begin
                    res.lift_duty  = LIFT_RAISED;
                    res.reach_duty = REACH_RAISED;
                end
            end
        end
        else if (move_next == M_CLAW)
        begin
            res.claw_update = 1'b1;
            res.claw_duty   = claw_open_next ? CLAW_OPEN : CLAW_CLOSED;
        end

        // home pose overrides all servo duties while waiting
        if (task_next == T_WAIT)
        begin
            res.arm_update  = 1'b1;
            res.rot_duty    = HOME_ROT;
            res.lift_duty   = LIFT_RAISED;
            res.reach_duty  = REACH_RAISED;
            res.claw_update = 1'b1;
            res.claw_duty   = CLAW_OPEN;
        end
    end

    // State update on each processed period
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_reg       <= T_WAIT;
            prev_task_reg  <= T_WAIT;
            move_reg       <= M_IDLE;
            pstart_reg     <= '0;
            start_pend_reg <= 1'b0;
            move_req_reg   <= 1'b0;
            move_done_reg  <= 1'b0;
            claw_due_reg   <= 1'b0;
            claw_open_reg  <= 1'b1;
            sel_mode_reg   <= 1'b0;
            sel_cell_reg   <= 4'd1;
            act_mode_reg   <= 1'b0;
            act_cell_reg   <= 4'd1;
        end
        else if (step)
        begin
            task_reg       <= task_next;
            prev_task_reg  <= prev_task_next;
            move_reg       <= move_next;
            pstart_reg     <= pstart_next;
            start_pend_reg <= start_pend_next;
            move_req_reg   <= move_req_next;
            move_done_reg  <= move_done_next;
            claw_due_reg   <= claw_due_next;
            claw_open_reg  <= claw_open_next;
            sel_mode_reg   <= sel_mode_next;
            sel_cell_reg   <= sel_cell_next;
            act_mode_reg   <= act_mode_next;
            act_cell_reg   <= act_cell_next;
        end
    end

endmodule

`default_nettype wire

### src/pick_place_sequencer.sv
// Top level of the pick-and-place sequencer: input register, sequencer, result register.
// Depends on pps_pkg, pps_if, pps_cfg_regs and pps_seq.
`timescale 1ns / 1ps
`default_nettype none

// Each input transfer is one control period (timestamp plus optional command
// byte) and yields exactly one result transfer with the servo duties written
// in that period and the task and move phases. Throughput is one item per
// clock while result.ready holds; items pass the input register, then the
// result register, with the whole period step done in the logic between them.
// The input side keeps accepting while a result waits, and stalls only when
// both registers are full. Register writes are taken at any time on the cfg
// channel (always ready) but should be made while the block is idle. TIME_BITS
// sets the width of the phase timer; elapsed time wraps modulo 2^TIME_BITS.

module pick_place_sequencer #(
    parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pps_in_if.sink    item,
    pps_out_if.source result,
    pps_cfg_if.sink   cfg
);
    import pps_pkg::*;

    logic    item_vld_reg;
    item_t   item_reg;
    logic    res_vld_reg;
    result_t res_reg;
    cfg_t    regs;
    result_t res_comb;
    logic    advance;

    // A held item moves on when the result register is free or draining
    assign advance    = item_vld_reg && (!res_vld_reg || result.ready);
    assign item.ready = !item_vld_reg || advance;

    pps_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    pps_seq #(
        .TIME_BITS (TIME_BITS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .cfg   (regs),
        .res   (res_comb)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            if (item.ready)
                item_vld_reg <= item.valid;
            if (advance)
                res_vld_reg <= 1'b1;
            else if (result.ready)
                res_vld_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg.now_ms    <= item.now_ms;
            item_reg.key_valid <= item.key_valid;
            item_reg.key_byte  <= item.key_byte;
        end
        if (advance)
            res_reg <= res_comb;
    end

    // Result channel
    assign result.valid       = res_vld_reg;
    assign result.arm_update  = res_reg.arm_update;
    assign result.rot_duty    = res_reg.rot_duty;
    assign result.lift_duty   = res_reg.lift_duty;
    assign result.reach_duty  = res_reg.reach_duty;
    assign result.claw_update = res_reg.claw_update;
    assign result.claw_duty   = res_reg.claw_duty;
    assign result.task_phase  = res_reg.task_phase;
    assign result.move_phase  = res_reg.move_phase;

endmodule

`default_nettype wire
